FILE: rtl/core/spc_pkg.sv
// Package for the SMBus PEC read checker: item types, status and op codes,
// register indexes and reset values, and the CRC-8 byte update.
// No dependencies.
package spc_pkg;

  localparam logic [7:0] MAX_BLOCK_LEN = 8'd60;
  localparam logic [7:0] CRC_POLY      = 8'h07;

  localparam logic [1:0] OP_NEW      = 2'd0;
  localparam logic [1:0] OP_RX       = 2'd1;
  localparam logic [1:0] OP_BUS_FAIL = 2'd2;

  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_OK          = 3'd1;
  localparam logic [2:0] ST_PEC_RETRY   = 3'd2;
  localparam logic [2:0] ST_COUNT_RETRY = 3'd3;
  localparam logic [2:0] ST_BUS_RETRY   = 3'd4;
  localparam logic [2:0] ST_GAVE_UP     = 3'd5;
  localparam logic [2:0] ST_TOO_LONG    = 3'd6;
  localparam logic [2:0] ST_IGNORED     = 3'd7;

  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_RETRY_LIMIT   = 1'b1;

  localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd11;
  localparam logic [2:0] RETRY_LIMIT_RST   = 3'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] command_code;
    logic       is_block;
    logic [7:0] request_length;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [5:0]  data_index;
    logic        is_payload;
    logic [15:0] word_value;
    logic [2:0]  attempt;
    logic [7:0]  pec_error_count;
    logic [31:0] failure_count;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic [6:0] slave_address;
    logic [2:0] retry_limit;
  } cfg_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/spc_in_if.sv
// Request and received-byte channel of the SMBus PEC read checker.
// Depends on spc_pkg.
interface spc_in_if;
  import spc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

FILE: rtl/core/spc_out_if.sv
// Result channel of the SMBus PEC read checker.
// Depends on spc_pkg.
interface spc_out_if;
  import spc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

FILE: rtl/core/spc_seed.sv
// CRC-8 seed of one attempt: write address, command and read address bytes.
// Depends on spc_pkg.
module spc_seed (
  input  logic [6:0] slave_address,
  input  logic [7:0] command,
  output logic [7:0] seed
);
  import spc_pkg::*;

  logic [7:0] addr_wr;
  logic [7:0] crc_a;
  logic [7:0] crc_b;

  assign addr_wr = {slave_address, 1'b0};
  assign crc_a   = crc8_feed(8'd0, addr_wr);
  assign crc_b   = crc8_feed(crc_a, command);
  assign seed    = crc8_feed(crc_b, {slave_address, 1'b1});

endmodule

FILE: rtl/core/spc_step.sv
// Transfer state of the SMBus PEC read checker and the per-item update logic.
// Depends on spc_pkg and spc_seed.
module spc_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  spc_pkg::in_item_t item,
  input  spc_pkg::cfg_t     cfg,
  output spc_pkg::out_item_t res
);
  import spc_pkg::*;

  logic [7:0]  crc_r, crc_nxt;
  logic        active_r, active_nxt;
  logic        block_mode_r, block_mode_nxt;
  logic [7:0]  saved_command_r, saved_command_nxt;
  logic [7:0]  length_limit_r, length_limit_nxt;
  logic [7:0]  byte_position_r, byte_position_nxt;
  logic [7:0]  received_count_r, received_count_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic [2:0]  attempt_r, attempt_nxt;
  logic [7:0]  pec_errors_r, pec_errors_nxt;
  logic [31:0] given_up_r, given_up_nxt;

  logic [7:0] seed_cmd;
  logic [7:0] seed;
  logic [7:0] crc_rx;
  logic       fail;
  logic [2:0] retry_code;

  assign seed_cmd = (item.op == OP_NEW) ? item.command_code : saved_command_r;
  assign crc_rx   = crc8_feed(crc_r, item.rx_byte);

  spc_seed u_seed (
    .slave_address(cfg.slave_address),
    .command      (seed_cmd),
    .seed         (seed)
  );

  always_comb begin
    crc_nxt            = crc_r;
    active_nxt         = active_r;
    block_mode_nxt     = block_mode_r;
    saved_command_nxt  = saved_command_r;
    length_limit_nxt   = length_limit_r;
    byte_position_nxt  = byte_position_r;
    received_count_nxt = received_count_r;
    low_byte_nxt       = low_byte_r;
    attempt_nxt        = attempt_r;
    pec_errors_nxt     = pec_errors_r;
    given_up_nxt       = given_up_r;
    fail               = 1'b0;
    retry_code         = ST_BUS_RETRY;
    res                = '0;
    res.status         = ST_IGNORED;

    case (item.op)
      OP_NEW: begin
        if (item.is_block && (item.request_length > MAX_BLOCK_LEN)) begin
          active_nxt   = 1'b0;
          attempt_nxt  = 3'd0;
          res.status   = ST_TOO_LONG;
          res.done_res = 1'b1;
        end else begin
          active_nxt         = 1'b1;
          block_mode_nxt     = item.is_block;
          saved_command_nxt  = item.command_code;
          length_limit_nxt   = item.request_length;
          attempt_nxt        = 3'd1;
          crc_nxt            = seed;
          byte_position_nxt  = 8'd0;
          received_count_nxt = 8'd0;
          low_byte_nxt       = 8'd0;
          res.status         = ST_BUSY;
        end
      end
      OP_BUS_FAIL: begin
        if (active_r) begin
          fail       = 1'b1;
          retry_code = ST_BUS_RETRY;
        end
      end
      OP_RX: begin
        if (active_r && !block_mode_r) begin
          if (byte_position_r == 8'd0 || byte_position_r == 8'd1) begin
            if (byte_position_r == 8'd0) begin
              low_byte_nxt = item.rx_byte;
            end else begin
              received_count_nxt = item.rx_byte;
            end
            crc_nxt           = crc_rx;
            res.is_payload    = 1'b1;
            res.data_byte     = item.rx_byte;
            res.data_index    = byte_position_r[5:0];
            byte_position_nxt = byte_position_r + 8'd1;
            res.status        = ST_BUSY;
          end else if (item.rx_byte == crc_r) begin
            res.word_value = {received_count_r, low_byte_r};
            active_nxt     = 1'b0;
            res.status     = ST_OK;
            res.done_res   = 1'b1;
          end else begin
            pec_errors_nxt = pec_errors_r + 8'd1;
            fail           = 1'b1;
            retry_code     = ST_PEC_RETRY;
          end
        end else if (active_r) begin
          if (!low_byte_r[0]) begin
            crc_nxt = crc_rx;
            if (item.rx_byte > length_limit_r) begin
              fail       = 1'b1;
              retry_code = ST_COUNT_RETRY;
            end else begin
              received_count_nxt = item.rx_byte;
              low_byte_nxt       = 8'd1;
              byte_position_nxt  = 8'd0;
              res.status         = ST_BUSY;
            end
          end else if (byte_position_r < received_count_r) begin
            crc_nxt           = crc_rx;
            res.is_payload    = 1'b1;
            res.data_byte     = item.rx_byte;
            res.data_index    = byte_position_r[5:0];
            byte_position_nxt = byte_position_r + 8'd1;
            res.status        = ST_BUSY;
          end else if (item.rx_byte == crc_r) begin
            active_nxt   = 1'b0;
            res.status   = ST_OK;
            res.done_res = 1'b1;
          end else begin
            pec_errors_nxt = pec_errors_r + 8'd1;
            fail           = 1'b1;
            retry_code     = ST_PEC_RETRY;
          end
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase

    if (fail) begin
      if (attempt_r >= cfg.retry_limit) begin
        given_up_nxt = given_up_r + 32'd1;
        active_nxt   = 1'b0;
        res.done_res = 1'b1;
        res.status   = ST_GAVE_UP;
      end else begin
        attempt_nxt        = attempt_r + 3'd1;
        crc_nxt            = seed;
        byte_position_nxt  = 8'd0;
        received_count_nxt = 8'd0;
        low_byte_nxt       = 8'd0;
        res.status         = retry_code;
      end
    end

    res.attempt         = attempt_nxt;
    res.pec_error_count = pec_errors_nxt;
    res.failure_count   = given_up_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r            <= '0;
      active_r         <= 1'b0;
      block_mode_r     <= 1'b0;
      saved_command_r  <= '0;
      length_limit_r   <= '0;
      byte_position_r  <= '0;
      received_count_r <= '0;
      low_byte_r       <= '0;
      attempt_r        <= '0;
      pec_errors_r     <= '0;
      given_up_r       <= '0;
    end else if (step_en) begin
      crc_r            <= crc_nxt;
      active_r         <= active_nxt;
      block_mode_r     <= block_mode_nxt;
      saved_command_r  <= saved_command_nxt;
      length_limit_r   <= length_limit_nxt;
      byte_position_r  <= byte_position_nxt;
      received_count_r <= received_count_nxt;
      low_byte_r       <= low_byte_nxt;
      attempt_r        <= attempt_nxt;
      pec_errors_r     <= pec_errors_nxt;
      given_up_r       <= given_up_nxt;
    end
  end

  a_done_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |=> !active_r)
    else $error("finished request left active");

  a_block_position: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && block_mode_r |-> byte_position_r <= received_count_r)
    else $error("block position beyond byte count");

  a_word_position: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && !block_mode_r |-> byte_position_r <= 8'd2)
    else $error("word position beyond PEC byte");

  a_pec_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.status == ST_PEC_RETRY) |=> pec_errors_r == 8'($past(pec_errors_r) + 8'd1))
    else $error("PEC retry not counted");

endmodule

FILE: rtl/core/smbus_pec_read_checker.sv
// Top level of the SMBus PEC read checker: input register, configuration
// registers, transfer state and result register. Depends on spc_pkg,
// spc_in_if, spc_out_if, spc_seed and spc_step.
//
//   Channel  Direction  Handshake        Payload
//   in_if    sink       valid / ready    spc_pkg::in_item_t
//   out_if   source     valid / ready    spc_pkg::out_item_t
//   cfg_*    input      cfg_we           cfg_index, cfg_wdata
//
// Each accepted input transfer is held in the input register and is stepped into
// the result register once that register is free; its result then transfers
// on out_if. One item is taken every cycle while the result side keeps up;
// the CRC byte update and the three-byte seed are combinational XOR logic.
// Reset is synchronous and needs no clearing pass. When the result register is
// held, the input register holds too and in_if.ready falls once both are full.
module smbus_pec_read_checker (
  input  logic             clk,
  input  logic             rst_n,
  spc_in_if.sink           in_if,
  spc_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [6:0]       cfg_wdata
);
  import spc_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_item_r;
  logic      in_v_r;
  out_item_t out_item_r;
  logic      out_v_r;
  out_item_t res;
  logic      out_free;
  logic      advance;

  assign out_free    = !out_v_r || out_if.ready;
  assign advance     = in_v_r && out_free;
  assign in_if.ready = !in_v_r || advance;

  assign out_if.valid = out_v_r;
  assign out_if.item  = out_item_r;

  spc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address <= SLAVE_ADDRESS_RST;
      cfg_r.retry_limit   <= RETRY_LIMIT_RST;
      in_v_r              <= 1'b0;
      out_v_r             <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDRESS: cfg_r.slave_address <= cfg_wdata;
          CFG_RETRY_LIMIT:   cfg_r.retry_limit   <= cfg_wdata[2:0];
          default:           cfg_r               <= cfg_r;
        endcase
      end
      if (in_if.ready) begin
        in_v_r <= in_if.valid;
      end
      if (out_free) begin
        out_v_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r <= in_if.item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

endmodule
